// ===== hdl/lprd_pkg.sv =====
// Shared types and constants for the length-prefixed record deframer.
`timescale 1ns / 1ps

package lprd_pkg;

   // Header geometry in bytes
   localparam int unsigned LEN_BYTES       = 4;
   localparam int unsigned TYPED_HDR_BYTES = 8;

   // Widths of the fields and counters
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned WORD_W       = 32;
   localparam int unsigned PIECE_W      = 17;
   localparam int unsigned LEFT_W       = 31;
   localparam int unsigned HDR_CNT_W    = 3;
   localparam int unsigned CSR_INDEX_W  = 8;

   // Reset value of the piece size register
   localparam logic [PIECE_W-1:0] MAX_PIECE_RESET = 17'd4096;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TYPED_MODE = 8'd0,
      CSR_MAX_PIECE  = 8'd1
   } csr_index_type;

   // Kind of a result item
   typedef enum logic {
      KIND_PAYLOAD   = 1'b0,
      KIND_END_ERROR = 1'b1
   } result_kind_type;

   // Configuration handed to the parser
   typedef struct packed {
      logic               typed_mode;
      logic [PIECE_W-1:0] max_piece_bytes;
   } cfg_type;

   // One result item
   typedef struct packed {
      result_kind_type    result_kind;
      logic [BYTE_W-1:0]  payload_byte;
      logic [WORD_W-1:0]  record_tag;
      logic               piece_last;
      logic               piece_truncated;
   } rsp_item_type;

endpackage

// ===== hdl/lprd_parser.sv =====
// Header and payload tracking: turns each accepted stream item into at most one result.
`timescale 1ns / 1ps

module lprd_parser
   import lprd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                item_accept,
   input  logic [BYTE_W-1:0]   stream_byte,
   input  logic                end_of_stream,
   output logic                result_valid,
   output rsp_item_type        result_item
);

   logic [HDR_CNT_W-1:0] header_byte_count_ff, header_byte_count_in;
   logic [WORD_W-1:0]    length_word_ff, length_word_in;
   logic [WORD_W-1:0]    type_word_ff, type_word_in;
   logic [LEFT_W-1:0]    bytes_left_ff, bytes_left_in;
   logic [PIECE_W-1:0]   piece_byte_count_ff, piece_byte_count_in;
   logic                 in_payload_ff, in_payload_in;

   logic [HDR_CNT_W-1:0] hdr_bytes;
   logic [HDR_CNT_W-1:0] idx_next;
   logic [PIECE_W-1:0]   max_piece;
   logic [PIECE_W-1:0]   piece_cnt;
   logic [LEFT_W-1:0]    left_dec;
   logic                 piece_done;
   logic                 piece_full;

   // Per-item next state and result
   always_comb begin
      header_byte_count_in = header_byte_count_ff;
      length_word_in       = length_word_ff;
      type_word_in         = type_word_ff;
      bytes_left_in        = bytes_left_ff;
      piece_byte_count_in  = piece_byte_count_ff;
      in_payload_in        = in_payload_ff;
      result_valid         = 1'b0;
      result_item          = '0;

      hdr_bytes = cfg.typed_mode ? HDR_CNT_W'(TYPED_HDR_BYTES - 1) : HDR_CNT_W'(LEN_BYTES - 1);
      idx_next  = header_byte_count_ff + 3'd1;
      max_piece = (cfg.max_piece_bytes == '0) ? PIECE_W'(1) : cfg.max_piece_bytes;
      piece_cnt = piece_byte_count_ff + PIECE_W'(1);
      left_dec  = (bytes_left_ff != '0) ? bytes_left_ff - LEFT_W'(1) : bytes_left_ff;
      piece_done = (left_dec == '0);
      piece_full = (piece_cnt >= max_piece);

      if (item_accept) begin
         if (end_of_stream) begin
            // End of stream inside a record gives an error marker and drops the record
            if (in_payload_ff || header_byte_count_ff != '0) begin
               result_valid                = 1'b1;
               result_item.result_kind     = KIND_END_ERROR;
               result_item.record_tag      = in_payload_ff ? type_word_ff : '0;
               result_item.piece_last      = 1'b1;
               header_byte_count_in        = '0;
               in_payload_in               = 1'b0;
               bytes_left_in               = '0;
               piece_byte_count_in         = '0;
            end
         end else if (!in_payload_ff) begin
            // Collect a header byte into the length or type word
            if (header_byte_count_ff == '0) begin
               length_word_in = '0;
               type_word_in   = '0;
            end
            if (header_byte_count_ff < HDR_CNT_W'(LEN_BYTES)) begin
               length_word_in[8*header_byte_count_ff[1:0] +: 8] = stream_byte;
            end else begin
               type_word_in[8*header_byte_count_ff[1:0] +: 8] = stream_byte;
            end
            if (header_byte_count_ff >= hdr_bytes) begin
               // Header complete: skip empty or flagged records
               if (!cfg.typed_mode) begin
                  type_word_in = '0;
               end
               header_byte_count_in = '0;
               if (length_word_in == '0 || length_word_in[WORD_W-1]) begin
                  in_payload_in = 1'b0;
               end else begin
                  bytes_left_in       = length_word_in[LEFT_W-1:0];
                  piece_byte_count_in = '0;
                  in_payload_in       = 1'b1;
               end
            end else begin
               header_byte_count_in = idx_next;
            end
         end else begin
            // Payload byte with piece bookkeeping
            result_valid                 = 1'b1;
            result_item.result_kind      = KIND_PAYLOAD;
            result_item.payload_byte     = stream_byte;
            result_item.record_tag       = type_word_ff;
            result_item.piece_last       = piece_done || piece_full;
            result_item.piece_truncated  = piece_full && !piece_done;
            bytes_left_in                = left_dec;
            if (piece_done) begin
               header_byte_count_in = '0;
               in_payload_in        = 1'b0;
               bytes_left_in        = '0;
               piece_byte_count_in  = '0;
            end else if (piece_full) begin
               piece_byte_count_in = '0;
            end else begin
               piece_byte_count_in = piece_cnt;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_count_ff <= '0;
         length_word_ff       <= '0;
         type_word_ff         <= '0;
         bytes_left_ff        <= '0;
         piece_byte_count_ff  <= '0;
         in_payload_ff        <= 1'b0;
      end else begin
         header_byte_count_ff <= header_byte_count_in;
         length_word_ff       <= length_word_in;
         type_word_ff         <= type_word_in;
         bytes_left_ff        <= bytes_left_in;
         piece_byte_count_ff  <= piece_byte_count_in;
         in_payload_ff        <= in_payload_in;
      end
   end

endmodule

// ===== hdl/lprd_skid.sv =====
// Output register with a skid stage, so the input side never waits on the output combinationally.
`timescale 1ns / 1ps

module lprd_skid
   import lprd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  rsp_item_type  in_item,
   output logic          in_ready,
   output logic          out_valid,
   output rsp_item_type  out_item,
   input  logic          out_ready
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_item_ff, main_item_in;
   rsp_item_type skid_item_ff, skid_item_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_item_ff;

   // Move items between the main and skid registers
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_item_in  = main_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || out_ready) begin
            main_item_in  = in_item;
            main_valid_in = 1'b1;
         end else begin
            skid_item_in  = in_item;
            skid_valid_in = 1'b1;
         end
      end else if (out_ready) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

// ===== hdl/length_prefixed_record_deframer.sv =====
// Top level of the length-prefixed record deframer: ports, configuration registers and wiring.
`timescale 1ns / 1ps

// The deframer takes one stream byte per clock while req_tready is high and returns each
// payload byte with its record type and piece marks from an output register; a two-entry
// output buffer takes one more item after the output stalls, so the sustained rate is one
// item per clock whenever the output is taken. Header bytes give no result, and an
// end-of-stream item inside a record gives one error marker. Configuration writes are
// accepted in the cycle they are offered and must only be made while no item is in flight.
module length_prefixed_record_deframer
   import lprd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Input stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] stream_byte
   input  logic                    req_tlast,   // end_of_stream
   // Result stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [39:0]             rsp_tdata,   // [7:0] payload_byte, [39:8] record_tag
   output logic [1:0]              rsp_tuser,   // [0] result_kind, [1] piece_truncated
   output logic                    rsp_tlast,   // piece_last
   // Configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [PIECE_W-1:0]      csr_data
);

   logic               typed_mode_ff, typed_mode_in;
   logic [PIECE_W-1:0] max_piece_ff, max_piece_in;
   cfg_type            cfg;
   logic               item_accept;
   logic               result_valid;
   rsp_item_type       result_item;
   rsp_item_type       out_item;

   assign csr_ready   = 1'b1;
   assign item_accept = req_tvalid && req_tready;
   assign cfg         = '{typed_mode: typed_mode_ff, max_piece_bytes: max_piece_ff};

   // Configuration register writes; unknown indexes are ignored
   always_comb begin
      typed_mode_in = typed_mode_ff;
      max_piece_in  = max_piece_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TYPED_MODE: typed_mode_in = csr_data[0];
            CSR_MAX_PIECE:  max_piece_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         typed_mode_ff <= 1'b0;
         max_piece_ff  <= MAX_PIECE_RESET;
      end else begin
         typed_mode_ff <= typed_mode_in;
         max_piece_ff  <= max_piece_in;
      end
   end

   lprd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .item_accept   (item_accept),
      .stream_byte   (req_tdata),
      .end_of_stream (req_tlast),
      .result_valid  (result_valid),
      .result_item   (result_item)
   );

   lprd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_item   (result_item),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .out_ready (rsp_tready)
   );

   // Pack the result item onto the stream ports
   assign rsp_tdata = {out_item.record_tag, out_item.payload_byte};
   assign rsp_tuser = {out_item.piece_truncated, out_item.result_kind};
   assign rsp_tlast = out_item.piece_last;

endmodule
